FILE: src/tcpct_pkg.sv
// ----------------------------------------------------------------------------
// tcpct_pkg
// Shared types and constants for the TCP client connection tracker.
// ----------------------------------------------------------------------------
package tcpct_pkg;

  // Connection phase. The fourth code is never entered.
  typedef enum logic [1:0] {
    PH_CLOSED   = 2'd0,
    PH_SYN_SENT = 2'd1,
    PH_ESTAB    = 2'd2
  } conn_phase_t;

  // Event kind carried in the func field of an input beat.
  localparam logic FUNC_SEND    = 1'b0;
  localparam logic FUNC_SEGMENT = 1'b1;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned LEN_W = 16;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [LEN_W-1:0] len_t;

endpackage

FILE: src/tcpct_if.sv
// ----------------------------------------------------------------------------
// tcpct_evt_if / tcpct_seg_if
// Valid/ready channels for tracker events and transmitted segment headers.
// ----------------------------------------------------------------------------
interface tcpct_evt_if import tcpct_pkg::*; ();
  logic valid;
  logic ready;
  logic func;
  len_t payload_length;
  seq_t rx_seq;
  seq_t rx_ack_seq;
  logic rx_syn;
  logic rx_ack;

  modport source (output valid, func, payload_length, rx_seq, rx_ack_seq,
                  rx_syn, rx_ack, input ready);
  modport sink   (input valid, func, payload_length, rx_seq, rx_ack_seq,
                  rx_syn, rx_ack, output ready);
endinterface

interface tcpct_seg_if import tcpct_pkg::*; ();
  logic valid;
  logic ready;
  seq_t tx_seq;
  seq_t tx_ack_seq;
  logic tx_syn;
  logic tx_ack;
  len_t tx_data_length;
  logic deliver_payload;
  logic became_established;
  seq_t unacked_seq;

  modport source (output valid, tx_seq, tx_ack_seq, tx_syn, tx_ack,
                  tx_data_length, deliver_payload, became_established,
                  unacked_seq, input ready);
  modport sink   (input valid, tx_seq, tx_ack_seq, tx_syn, tx_ack,
                  tx_data_length, deliver_payload, became_established,
                  unacked_seq, output ready);
endinterface

FILE: src/tcp_client_connection_tracker.sv
// ----------------------------------------------------------------------------
// tcp_client_connection_tracker
// Client side of a minimal TCP connection: handshake and sequence tracking.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one event per beat: an application send request (func 0) or
//   the header summary of a received segment (func 1). seg carries the header
//   of each segment to transmit, at most one per event.
//   cfg_we/cfg_data write the initial send sequence number; write it only
//   while no event is in flight.
// Throughput:
//   A result appears on seg in the cycle after its event beat is taken. One
//   event is accepted every cycle while evt.ready is high; the connection
//   state update is a single level of 32-bit add and compare between the
//   event beat and the state and output registers.
// Stall:
//   seg is held in an output register. While it is full and not taken,
//   evt.ready is low; it rises again in the cycle the result is taken, so a
//   waiting result never costs a cycle of input.
// Reset:
//   rst (synchronous) returns the connection to CLOSED, clears all sequence
//   state and the configuration register, and empties the output register.
// ----------------------------------------------------------------------------
module tcp_client_connection_tracker import tcpct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  seq_t       cfg_data,
  tcpct_evt_if.sink  evt,
  tcpct_seg_if.source seg
);

  conn_phase_t phase, phase_next;
  seq_t initial_send_seq;
  seq_t snd_next, snd_next_next;
  seq_t snd_unacked, snd_unacked_next;
  seq_t rcv_next, rcv_next_next;

  logic emit;
  seq_t o_seq;
  seq_t o_ack_seq;
  logic o_syn;
  logic o_ack;
  len_t o_len;
  logic o_deliver;
  logic o_estab;

  logic evt_take;
  seq_t ack_diff;
  seq_t len_ext;

  // The event side runs whenever the output register is empty or emptying.
  assign evt.ready = !seg.valid || seg.ready;
  assign evt_take  = evt.valid && evt.ready;

  assign len_ext  = {{(SEQ_W-LEN_W){1'b0}}, evt.payload_length};
  assign ack_diff = evt.rx_ack_seq - snd_unacked;

  // Next connection state and the result of the current event.
  always_comb begin
    phase_next       = phase;
    snd_next_next    = snd_next;
    snd_unacked_next = snd_unacked;
    rcv_next_next    = rcv_next;
    emit             = 1'b0;
    o_seq            = snd_next;
    o_ack_seq        = '0;
    o_syn            = 1'b0;
    o_ack            = 1'b0;
    o_len            = '0;
    o_deliver        = 1'b0;
    o_estab          = 1'b0;
    if (evt.func == FUNC_SEND) begin
      unique case (phase)
        PH_CLOSED: begin
          snd_unacked_next = initial_send_seq;
          snd_next_next    = initial_send_seq + seq_t'(1);
          phase_next       = PH_SYN_SENT;
          emit             = 1'b1;
          o_seq            = initial_send_seq;
          o_syn            = 1'b1;
        end
        PH_ESTAB: begin
          snd_next_next = snd_next + len_ext;
          emit          = 1'b1;
          o_ack         = 1'b1;
          o_ack_seq     = rcv_next;
          o_len         = evt.payload_length;
        end
        default: ;
      endcase
    end else begin
      unique case (phase)
        PH_SYN_SENT: begin
          // Only a SYN+ACK completes the handshake.
          if (evt.rx_syn && evt.rx_ack) begin
            rcv_next_next    = evt.rx_seq + seq_t'(1);
            snd_unacked_next = snd_unacked + seq_t'(1);
            phase_next       = PH_ESTAB;
            emit             = 1'b1;
            o_ack            = 1'b1;
            o_ack_seq        = evt.rx_seq + seq_t'(1);
            o_estab          = 1'b1;
          end
        end
        PH_ESTAB: begin
          // Serial-number compare: advance only on a forward distance below
          // half the sequence space.
          if (evt.rx_ack && ack_diff != '0 && !ack_diff[SEQ_W-1]) begin
            snd_unacked_next = evt.rx_ack_seq;
          end
          if (evt.payload_length != '0) begin
            rcv_next_next = evt.rx_seq + len_ext;
            emit          = 1'b1;
            o_ack         = 1'b1;
            o_ack_seq     = evt.rx_seq + len_ext;
            o_deliver     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_send_seq <= '0;
    end else if (cfg_we) begin
      initial_send_seq <= cfg_data;
    end
  end

  // Connection state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_CLOSED;
      snd_next    <= '0;
      snd_unacked <= '0;
      rcv_next    <= '0;
    end else if (evt_take) begin
      phase       <= phase_next;
      snd_next    <= snd_next_next;
      snd_unacked <= snd_unacked_next;
      rcv_next    <= rcv_next_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
    end else if (evt_take) begin
      seg.valid <= emit;
    end else if (seg.ready) begin
      seg.valid <= 1'b0;
    end
  end

  // Output register payload, loaded only when a result is produced.
  always_ff @(posedge clk) begin
    if (evt_take && emit) begin
      seg.tx_seq             <= o_seq;
      seg.tx_ack_seq         <= o_ack_seq;
      seg.tx_syn             <= o_syn;
      seg.tx_ack             <= o_ack;
      seg.tx_data_length     <= o_len;
      seg.deliver_payload    <= o_deliver;
      seg.became_established <= o_estab;
      seg.unacked_seq        <= snd_unacked_next;
    end
  end

endmodule

FILE: src/tcpct_checker.sv
// ----------------------------------------------------------------------------
// tcpct_checker
// Port-level checks for the TCP client connection tracker, bound to the top.
// ----------------------------------------------------------------------------
module tcpct_checker import tcpct_pkg::*; (
  input logic clk,
  input logic rst,
  input logic evt_ready,
  input logic seg_valid,
  input logic seg_ready,
  input seq_t seg_tx_seq,
  input seq_t seg_tx_ack_seq,
  input logic seg_tx_syn,
  input logic seg_tx_ack,
  input len_t seg_tx_data_length,
  input logic seg_deliver_payload,
  input logic seg_became_established
);

  // A stalled beat keeps its header.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid && $stable(seg_tx_seq) &&
      $stable(seg_tx_ack_seq) && $stable(seg_tx_data_length))
    else $error("stalled segment beat changed");

  // Events are taken exactly when the output register has room.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    evt_ready == (!seg_valid || seg_ready))
    else $error("event ready does not follow output occupancy");

  // A SYN is a bare control segment.
  a_syn: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_tx_syn |-> !seg_tx_ack && seg_tx_data_length == '0 &&
      seg_tx_ack_seq == '0 && !seg_deliver_payload)
    else $error("SYN segment carries ACK or data");

  // Without ACK the acknowledgment number is zero.
  a_ackz: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_tx_ack |-> seg_tx_ack_seq == '0)
    else $error("acknowledgment number set without ACK");

  // The handshake completion is a pure ACK.
  a_estab: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_became_established |-> seg_tx_ack && !seg_deliver_payload &&
      seg_tx_data_length == '0)
    else $error("establishing segment is not a pure ACK");

endmodule

bind tcp_client_connection_tracker tcpct_checker u_tcpct_checker (
  .clk                    (clk),
  .rst                    (rst),
  .evt_ready              (evt.ready),
  .seg_valid              (seg.valid),
  .seg_ready              (seg.ready),
  .seg_tx_seq             (seg.tx_seq),
  .seg_tx_ack_seq         (seg.tx_ack_seq),
  .seg_tx_syn             (seg.tx_syn),
  .seg_tx_ack             (seg.tx_ack),
  .seg_tx_data_length     (seg.tx_data_length),
  .seg_deliver_payload    (seg.deliver_payload),
  .seg_became_established (seg.became_established)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TCP client connection tracker. Event beats are
// offered in random bursts while the segment side stalls on its own pattern.
// A scoreboard class keeps a private copy of the connection state, predicts
// the segment header for each accepted event and compares it field by field
// with the header that comes out.
// ----------------------------------------------------------------------------
import tcpct_pkg::*;

// One event beat as offered on the evt channel.
typedef struct packed {
  logic func;
  len_t payload_length;
  seq_t rx_seq;
  seq_t rx_ack_seq;
  logic rx_syn;
  logic rx_ack;
} evt_item_t;

// One segment header as taken from the seg channel.
typedef struct packed {
  seq_t tx_seq;
  seq_t tx_ack_seq;
  logic tx_syn;
  logic tx_ack;
  len_t tx_data_length;
  logic deliver_payload;
  logic became_established;
  seq_t unacked_seq;
} seg_hdr_t;

class conn_scoreboard;
  conn_phase_t phase;
  seq_t        isn;
  seq_t        snd_next;
  seq_t        snd_unacked;
  seq_t        rcv_next;
  seg_hdr_t    hdr_q[$];
  int unsigned failures;

  function new();
    phase       = PH_CLOSED;
    isn         = '0;
    snd_next    = '0;
    snd_unacked = '0;
    rcv_next    = '0;
    failures    = 0;
  endfunction

  function void set_isn(seq_t value);
    isn = value;
  endfunction

  function int unsigned pending();
    return hdr_q.size();
  endfunction

  // Advance the connection state for one accepted event beat and queue the
  // header it should produce, if any.
  function void note_event(evt_item_t e);
    seg_hdr_t h;
    seq_t     ack_gap;
    h = '0;
    if (e.func == FUNC_SEND) begin
      case (phase)
        PH_CLOSED: begin
          snd_unacked = isn;
          snd_next    = isn + 1;
          phase       = PH_SYN_SENT;
          h.tx_seq      = isn;
          h.tx_syn      = 1'b1;
          h.unacked_seq = snd_unacked;
          hdr_q.push_back(h);
        end
        PH_ESTAB: begin
          h.tx_seq         = snd_next;
          h.tx_ack_seq     = rcv_next;
          h.tx_ack         = 1'b1;
          h.tx_data_length = e.payload_length;
          snd_next         = snd_next + e.payload_length;
          h.unacked_seq    = snd_unacked;
          hdr_q.push_back(h);
        end
        default: ;
      endcase
    end else begin
      case (phase)
        PH_SYN_SENT: begin
          // Only a SYN+ACK completes the handshake.
          if (e.rx_syn && e.rx_ack) begin
            rcv_next    = e.rx_seq + 1;
            snd_unacked = snd_unacked + 1;
            phase       = PH_ESTAB;
            h.tx_seq             = snd_next;
            h.tx_ack_seq         = rcv_next;
            h.tx_ack             = 1'b1;
            h.became_established = 1'b1;
            h.unacked_seq        = snd_unacked;
            hdr_q.push_back(h);
          end
        end
        PH_ESTAB: begin
          // Serial-number compare: advance only when strictly ahead by less
          // than half the sequence space.
          if (e.rx_ack) begin
            ack_gap = e.rx_ack_seq - snd_unacked;
            if (ack_gap != '0 && !ack_gap[SEQ_W-1]) snd_unacked = e.rx_ack_seq;
          end
          if (e.payload_length != '0) begin
            rcv_next = e.rx_seq + e.payload_length;
            h.tx_seq          = snd_next;
            h.tx_ack_seq      = rcv_next;
            h.tx_ack          = 1'b1;
            h.deliver_payload = 1'b1;
            h.unacked_seq     = snd_unacked;
            hdr_q.push_back(h);
          end
        end
        default: ;
      endcase
    end
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      failures++;
    end
  endfunction

  // Compare one outgoing header with the oldest prediction.
  function void check_segment(seg_hdr_t got);
    seg_hdr_t want;
    if (hdr_q.size() == 0) begin
      $error("segment header with nothing predicted: tx_seq %h", got.tx_seq);
      failures++;
      return;
    end
    want = hdr_q.pop_front();
    check_field("tx_seq", want.tx_seq, got.tx_seq);
    check_field("tx_ack_seq", want.tx_ack_seq, got.tx_ack_seq);
    check_field("tx_syn", want.tx_syn, got.tx_syn);
    check_field("tx_ack", want.tx_ack, got.tx_ack);
    check_field("tx_data_length", want.tx_data_length, got.tx_data_length);
    check_field("deliver_payload", want.deliver_payload, got.deliver_payload);
    check_field("became_established", want.became_established,
                got.became_established);
    check_field("unacked_seq", want.unacked_seq, got.unacked_seq);
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_EVENTS = 600;
  localparam int unsigned LONG_HOLD     = 120;

  logic clk;
  logic rst;
  logic cfg_we;
  seq_t cfg_data;

  tcpct_evt_if evt_if ();
  tcpct_seg_if seg_if ();

  conn_scoreboard sb = new();

  // Long receiver hold-offs are requested by bumping hold_ask.
  int unsigned hold_ask;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned rx_cycle;

  tcp_client_connection_tracker u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .evt      (evt_if),
    .seg      (seg_if)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver stall pattern: the mode steps through four settings, from always
  // ready to mostly stalled. A requested long hold-off overrides it.
  always @(negedge clk) begin
    if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      seg_if.ready = 1'b0;
    end else begin
      rx_cycle++;
      case (rx_cycle[8:7])
        2'd0: seg_if.ready = 1'b1;
        2'd1: seg_if.ready = (rx_cycle[1:0] != 2'd3);
        2'd2: seg_if.ready = 1'($urandom_range(0, 1));
        default: seg_if.ready = (rx_cycle[3:0] < 4'd5);
      endcase
    end
  end

  // Check every header beat taken from the block.
  always @(posedge clk) begin
    if (!rst && seg_if.valid && seg_if.ready) begin
      sb.check_segment('{seg_if.tx_seq, seg_if.tx_ack_seq, seg_if.tx_syn,
                         seg_if.tx_ack, seg_if.tx_data_length,
                         seg_if.deliver_payload, seg_if.became_established,
                         seg_if.unacked_seq});
    end
  end

  function automatic evt_item_t mk_send(len_t len);
    evt_item_t e;
    e = '0;
    e.func = FUNC_SEND;
    e.payload_length = len;
    return e;
  endfunction

  function automatic evt_item_t mk_segment(len_t len, seq_t rseq, seq_t rack_seq,
                                           logic syn, logic ack);
    evt_item_t e;
    e.func           = FUNC_SEGMENT;
    e.payload_length = len;
    e.rx_seq         = rseq;
    e.rx_ack_seq     = rack_seq;
    e.rx_syn         = syn;
    e.rx_ack         = ack;
    return e;
  endfunction

  // Random event for an established connection. Ack numbers are mostly
  // placed near the current unacknowledged mark so that advances, repeats,
  // stale acks and the half-space boundary all come up.
  function automatic evt_item_t random_event();
    evt_item_t e;
    int unsigned pick;
    e.rx_seq     = $urandom;
    e.rx_ack_seq = $urandom;
    e.rx_syn     = 1'($urandom_range(0, 1));
    e.rx_ack     = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6) e.payload_length = len_t'($urandom_range(1, 1460));
    else if (pick == 6) e.payload_length = '1;
    else if (pick == 7) e.payload_length = len_t'($urandom);
    else e.payload_length = '0;
    if ($urandom_range(0, 99) < 45) begin
      e.func = FUNC_SEND;
    end else begin
      e.func   = FUNC_SEGMENT;
      e.rx_syn = ($urandom_range(0, 9) == 0);
      e.rx_ack = ($urandom_range(0, 99) < 85);
      if ($urandom_range(0, 9) < 7) e.rx_seq = sb.rcv_next;
      pick = $urandom_range(0, 99);
      if (pick < 40) e.rx_ack_seq = sb.snd_unacked + $urandom_range(1, 4000);
      else if (pick < 55) e.rx_ack_seq = sb.snd_next;
      else if (pick < 65) e.rx_ack_seq = sb.snd_unacked;
      else if (pick < 75) e.rx_ack_seq = sb.snd_unacked - $urandom_range(1, 4000);
      else if (pick < 80) e.rx_ack_seq = sb.snd_unacked + 32'h8000_0000;
      else if (pick < 85) e.rx_ack_seq = sb.snd_unacked + 32'h7fff_ffff;
      if (pick < 40 && e.payload_length == '0 && $urandom_range(0, 1) == 0) begin
        e.payload_length = len_t'($urandom_range(1, 64));
      end
    end
    return e;
  endfunction

  // Offer one event beat and hold it until the block takes it.
  task automatic offer_event(input evt_item_t e);
    @(negedge clk);
    evt_if.valid          = 1'b1;
    evt_if.func           = e.func;
    evt_if.payload_length = e.payload_length;
    evt_if.rx_seq         = e.rx_seq;
    evt_if.rx_ack_seq     = e.rx_ack_seq;
    evt_if.rx_syn         = e.rx_syn;
    evt_if.rx_ack         = e.rx_ack;
    do @(posedge clk); while (!evt_if.ready);
    sb.note_event(e);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk);
    evt_if.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop offering, let every predicted header arrive and then let the block
  // settle before the register is touched.
  task automatic write_isn_when_idle(input seq_t value);
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_isn(value);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned n;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_data              = '0;
    evt_if.valid          = 1'b0;
    evt_if.func           = FUNC_SEND;
    evt_if.payload_length = '0;
    evt_if.rx_seq         = '0;
    evt_if.rx_ack_seq     = '0;
    evt_if.rx_syn         = 1'b0;
    evt_if.rx_ack         = 1'b0;
    seg_if.ready          = 1'b0;
    hold_ask              = 0;
    hold_seen             = 0;
    hold_left             = 0;
    rx_cycle              = 0;
    burst_left            = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Segments while closed are dropped.
    write_isn_when_idle('0);
    offer_event(mk_segment(16'd100, 32'h0000_1234, 32'h0000_0005, 1'b1, 1'b1));
    offer_event(mk_segment('0, '0, '0, 1'b0, 1'b0));

    // Open with the top initial sequence number so that snd_next wraps.
    write_isn_when_idle('1);
    offer_event(mk_send(16'd5));
    offer_event(mk_send(16'd7));
    offer_event(mk_segment(16'd9, 32'h1111_0000, '1, 1'b1, 1'b0));
    offer_event(mk_segment(16'd9, 32'h2222_0000, '0, 1'b0, 1'b1));
    offer_event(mk_segment('0, 32'h3333_0000, '0, 1'b0, 1'b0));
    offer_event(mk_segment(16'd20, '1, '0, 1'b1, 1'b1));

    // Established: send lengths at the extremes.
    offer_event(mk_send('0));
    offer_event(mk_send('1));
    offer_event(mk_send(16'd1));

    // Ack compare corners and payload handling.
    offer_event(mk_segment('0, sb.rcv_next, sb.snd_unacked, 1'b0, 1'b1));
    offer_event(mk_segment('0, sb.rcv_next, sb.snd_unacked + 32'h8000_0000,
                           1'b0, 1'b1));
    offer_event(mk_segment('0, sb.rcv_next, sb.snd_unacked + 32'h7fff_ffff,
                           1'b0, 1'b1));
    offer_event(mk_segment(16'd5, sb.rcv_next, sb.snd_unacked + 10, 1'b0, 1'b0));
    offer_event(mk_segment('1, '1, sb.snd_unacked + 10, 1'b0, 1'b1));
    offer_event(mk_segment(16'd3, 32'h1234_5678, sb.snd_unacked - 1, 1'b0, 1'b1));
    offer_event(mk_segment('0, sb.rcv_next, sb.snd_unacked + 1, 1'b1, 1'b1));
    offer_event(mk_segment(16'd1, sb.rcv_next, sb.snd_unacked, 1'b1, 1'b0));
    offer_event(mk_send('1));

    // The register has no effect once established, but it must still take
    // a range of values.
    write_isn_when_idle(32'h8000_0000);

    // Random traffic in bursts with random gaps.
    for (int unsigned i = 0; i < RANDOM_EVENTS; i++) begin
      if (i == 150 || i == 480) hold_ask++;
      if (i == 300) write_isn_when_idle($urandom);
      if (i == 450) write_isn_when_idle(32'h7fff_ffff);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        n = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        idle_sender(n);
      end
      burst_left--;
      offer_event(random_event());
    end

    // Drain and finish.
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
